FILE: sv/tabs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabs_pkg: shared types and constants of the two-axis servo block
// Beat payloads, register map, filter coefficients, sequencer codes.
// ----------------------------------------------------------------------------
package tabs_pkg;

  // Field widths of the beats and registers.
  localparam int SAMPLE_W = 12;
  localparam int GAIN_W   = 40;
  localparam int ERR_W    = 14;
  localparam int SUM_W    = 32;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 38;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Accumulator widths: filter sum and PID total (gain * value * angle).
  localparam int ACC_W = 32;
  localparam int TOT_W = 80;
  localparam int MAG_W = 41;

  // Filter coefficients in Q2.14 (0.0134, 0.0267, 1.647, 0.701 rounded).
  localparam logic [MUL_A_W-1:0] COEF_B0 = 20'd220;
  localparam logic [MUL_A_W-1:0] COEF_B1 = 20'd437;
  localparam logic [MUL_A_W-1:0] COEF_A1 = 20'd26984;
  localparam logic [MUL_A_W-1:0] COEF_A2 = 20'd11485;

  // Angle scale in degrees and the duty mapping 6*(angle+90)+900 in Q8.8.
  localparam logic [MUL_A_W-1:0] ANGLE_SCALE = 20'd90;
  localparam int DUTY_SLOPE  = 1200 / 180;
  localparam int DUTY_OFFSET = (DUTY_SLOPE * 90 + 900) * 256;

  // Angle magnitude limit before the final saturation.
  localparam logic [MAG_W-1:0] ANGLE_LIMIT = 41'h100_0000_0000;

  // Register map: register i at byte address 8*i.
  typedef enum logic [2:0] {
    REG_SETPOINT_X = 3'd0,
    REG_SETPOINT_Y = 3'd1,
    REG_GAIN_P_X   = 3'd2,
    REG_GAIN_I_X   = 3'd3,
    REG_GAIN_D_X   = 3'd4,
    REG_GAIN_P_Y   = 3'd5,
    REG_GAIN_I_Y   = 3'd6,
    REG_GAIN_D_Y   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic                axis;
    logic [SAMPLE_W-1:0] raw_position;
  } in_t;

  typedef struct packed {
    logic                axis_out;
    logic [SAMPLE_W-1:0] filtered_position;
    logic signed [15:0]  angle_q8;
    logic [15:0]         duty_us;
  } out_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] setpoint_x;
    logic [SAMPLE_W-1:0] setpoint_y;
    logic [GAIN_W-1:0]   gain_p_x;
    logic [GAIN_W-1:0]   gain_i_x;
    logic [GAIN_W-1:0]   gain_d_x;
    logic [GAIN_W-1:0]   gain_p_y;
    logic [GAIN_W-1:0]   gain_i_y;
    logic [GAIN_W-1:0]   gain_d_y;
  } cfg_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_ERR,
    ST_SUM,
    ST_TERM,
    ST_DRAIN,
    ST_MAG,
    ST_OUT
  } state_t;

  // What to do with the registered product in the cycle after it is issued.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_FILT_ADD,
    ACT_FILT_SUB,
    ACT_LOAD_M,
    ACT_ADD_LO,
    ACT_ADD_HI
  } act_t;

endpackage

FILE: sv/tabs_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabs_cfg: configuration register file
// APB-style write and read of the setpoints and the PID gains.
// ----------------------------------------------------------------------------
module tabs_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output tabs_pkg::cfg_t      cfg
);
  import tabs_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[5:3]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes; values are masked to the register width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint_x <= 12'd2048;
      cfg_r.setpoint_y <= 12'd2048;
      cfg_r.gain_p_x   <= '0;
      cfg_r.gain_i_x   <= '0;
      cfg_r.gain_d_x   <= '0;
      cfg_r.gain_p_y   <= '0;
      cfg_r.gain_i_y   <= '0;
      cfg_r.gain_d_y   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SETPOINT_X: cfg_r.setpoint_x <= pwdata[SAMPLE_W-1:0];
        REG_SETPOINT_Y: cfg_r.setpoint_y <= pwdata[SAMPLE_W-1:0];
        REG_GAIN_P_X:   cfg_r.gain_p_x   <= pwdata[GAIN_W-1:0];
        REG_GAIN_I_X:   cfg_r.gain_i_x   <= pwdata[GAIN_W-1:0];
        REG_GAIN_D_X:   cfg_r.gain_d_x   <= pwdata[GAIN_W-1:0];
        REG_GAIN_P_Y:   cfg_r.gain_p_y   <= pwdata[GAIN_W-1:0];
        REG_GAIN_I_Y:   cfg_r.gain_i_y   <= pwdata[GAIN_W-1:0];
        REG_GAIN_D_Y:   cfg_r.gain_d_y   <= pwdata[GAIN_W-1:0];
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (idx)
      REG_SETPOINT_X: prdata = 64'(cfg_r.setpoint_x);
      REG_SETPOINT_Y: prdata = 64'(cfg_r.setpoint_y);
      REG_GAIN_P_X:   prdata = 64'(cfg_r.gain_p_x);
      REG_GAIN_I_X:   prdata = 64'(cfg_r.gain_i_x);
      REG_GAIN_D_X:   prdata = 64'(cfg_r.gain_d_x);
      REG_GAIN_P_Y:   prdata = 64'(cfg_r.gain_p_y);
      REG_GAIN_I_Y:   prdata = 64'(cfg_r.gain_i_y);
      REG_GAIN_D_Y:   prdata = 64'(cfg_r.gain_d_y);
    endcase
  end

endmodule

FILE: sv/tabs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabs_front: input side of the servo block
// Accepts sample beats into a two-entry queue that feeds the back end.
// ----------------------------------------------------------------------------
module tabs_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tabs_pkg::in_t in_data,
  output logic          q_valid,
  output tabs_pkg::in_t q_data,
  input  logic          q_pop
);
  import tabs_pkg::*;

  in_t        mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid & ~in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_data   = mem_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

FILE: sv/tabs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabs_back: filter and PID engine
// Runs the biquad and the PID step on one shared 20x38 multiplier.
// ----------------------------------------------------------------------------
module tabs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  tabs_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  tabs_pkg::in_t  q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output tabs_pkg::out_t out_data
);
  import tabs_pkg::*;

  state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  act_t act_r, act_nxt;

  logic                ax_r;
  logic [SAMPLE_W-1:0] x0_r;

  // Per-axis history.
  logic [SAMPLE_W-1:0]     raw1_r  [2];
  logic [SAMPLE_W-1:0]     raw2_r  [2];
  logic [SAMPLE_W-1:0]     filt1_r [2];
  logic [SAMPLE_W-1:0]     filt2_r [2];
  logic signed [ERR_W-1:0] perr_r  [2];
  logic signed [SUM_W-1:0] esum_r  [2];

  // Datapath registers.
  logic signed [ACC_W-1:0] acc_r;
  logic signed [TOT_W-1:0] tot_r;
  logic [PROD_W-1:0]       p_r;
  logic [MUL_B_W-1:0]      m_r;
  logic                    xneg_r;
  logic [SAMPLE_W-1:0]     y_r;
  logic signed [ERR_W-1:0] e_r;
  logic signed [ERR_W-1:0] de_r;
  logic signed [SUM_W-1:0] s_r;
  logic [MAG_W-1:0]        mag_r;
  logic                    negt_r;
  logic                    out_valid_r;
  out_t                    out_data_r;

  // Sequencer outputs.
  logic               clr;
  logic               do_err;
  logic               do_sum;
  logic               do_mag;
  logic               do_out;
  logic               latch_neg;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;

  // Term selection for the PID products.
  logic [1:0]              term;
  logic [1:0]              sub;
  logic signed [SUM_W-1:0] xsel;
  logic [SUM_W-1:0]        xmag;
  logic [GAIN_W-1:0]       gsel;

  // Combinational results of the error, sum, magnitude and output steps.
  logic [SAMPLE_W-1:0]     y_cl;
  logic [SAMPLE_W-1:0]     sp;
  logic signed [ERR_W-1:0] e_c;
  logic signed [ERR_W-1:0] de_c;
  logic signed [SUM_W:0]   sum_w;
  logic signed [SUM_W-1:0] s_c;
  logic [TOT_W-1:0]        abs_tot;
  logic [47:0]             mag_sh;
  logic [MAG_W-1:0]        mag_c;
  logic signed [MAG_W:0]   ang;
  logic signed [45:0]      duty_w;
  logic [15:0]             duty_c;
  logic signed [15:0]      ang_c;
  logic                    out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign term      = cnt_r[3:2];
  assign sub       = cnt_r[1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_FILT;
          cnt_nxt   = 4'd0;
        end
      end
      ST_FILT: begin
        if (cnt_r == 4'd5) begin
          state_nxt = ST_ERR;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      ST_ERR: state_nxt = ST_SUM;
      ST_SUM: begin
        state_nxt = ST_TERM;
        cnt_nxt   = 4'd0;
      end
      ST_TERM: begin
        if (cnt_r == 4'd11) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      ST_DRAIN: state_nxt = ST_MAG;
      ST_MAG:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Term operand: e, then de, then the error sum.
  always_comb begin
    unique case (term)
      2'd0:    xsel = SUM_W'(e_r);
      2'd1:    xsel = SUM_W'(de_r);
      default: xsel = s_r;
    endcase
    xmag = xsel[SUM_W-1] ? SUM_W'(-xsel) : SUM_W'(xsel);
    unique case ({ax_r, term})
      3'b000:  gsel = cfg.gain_p_x;
      3'b001:  gsel = cfg.gain_d_x;
      3'b010:  gsel = cfg.gain_i_x;
      3'b100:  gsel = cfg.gain_p_y;
      3'b101:  gsel = cfg.gain_d_y;
      3'b110:  gsel = cfg.gain_i_y;
      default: gsel = '0;
    endcase
  end

  // Sequencer outputs: multiplier operands and step strobes.
  always_comb begin
    clr       = 1'b0;
    do_err    = 1'b0;
    do_sum    = 1'b0;
    do_mag    = 1'b0;
    do_out    = 1'b0;
    latch_neg = 1'b0;
    q_pop     = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    act_nxt   = ACT_NONE;
    unique case (state_r)
      ST_IDLE: begin
        q_pop = q_valid;
        clr   = q_valid;
      end
      ST_FILT: begin
        unique case (cnt_r)
          4'd0: begin
            mul_a   = COEF_B0;
            mul_b   = MUL_B_W'(x0_r);
            act_nxt = ACT_FILT_ADD;
          end
          4'd1: begin
            mul_a   = COEF_B1;
            mul_b   = MUL_B_W'(raw1_r[ax_r]);
            act_nxt = ACT_FILT_ADD;
          end
          4'd2: begin
            mul_a   = COEF_B0;
            mul_b   = MUL_B_W'(raw2_r[ax_r]);
            act_nxt = ACT_FILT_ADD;
          end
          4'd3: begin
            mul_a   = COEF_A1;
            mul_b   = MUL_B_W'(filt1_r[ax_r]);
            act_nxt = ACT_FILT_ADD;
          end
          4'd4: begin
            mul_a   = COEF_A2;
            mul_b   = MUL_B_W'(filt2_r[ax_r]);
            act_nxt = ACT_FILT_SUB;
          end
          default: act_nxt = ACT_NONE;
        endcase
      end
      ST_ERR: do_err = 1'b1;
      ST_SUM: do_sum = 1'b1;
      ST_TERM: begin
        unique case (sub)
          2'd0: begin
            mul_a     = ANGLE_SCALE;
            mul_b     = MUL_B_W'(xmag);
            act_nxt   = ACT_LOAD_M;
            latch_neg = 1'b1;
          end
          2'd2: begin
            mul_a   = gsel[MUL_A_W-1:0];
            mul_b   = m_r;
            act_nxt = ACT_ADD_LO;
          end
          2'd3: begin
            mul_a   = gsel[GAIN_W-1:MUL_A_W];
            mul_b   = m_r;
            act_nxt = ACT_ADD_HI;
          end
          default: act_nxt = ACT_NONE;
        endcase
      end
      ST_DRAIN: act_nxt = ACT_NONE;
      ST_MAG:   do_mag  = 1'b1;
      ST_OUT:   do_out  = out_free;
      default:  act_nxt = ACT_NONE;
    endcase
  end

  // Filter output, error, difference and saturated error sum.
  always_comb begin
    if (acc_r[ACC_W-1]) begin
      y_cl = '0;
    end else if (|acc_r[ACC_W-2:26]) begin
      y_cl = '1;
    end else begin
      y_cl = acc_r[25:14];
    end
    sp    = ax_r ? cfg.setpoint_y : cfg.setpoint_x;
    e_c   = $signed({2'b00, y_cl}) - $signed({2'b00, sp});
    de_c  = e_c - perr_r[ax_r];
    sum_w = $signed({esum_r[ax_r][SUM_W-1], esum_r[ax_r]}) + (SUM_W+1)'(e_r);
    if (sum_w[SUM_W] != sum_w[SUM_W-1]) begin
      s_c = sum_w[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      s_c = sum_w[SUM_W-1:0];
    end
  end

  // Angle magnitude from the PID total, and the final angle and duty.
  always_comb begin
    abs_tot = tot_r[TOT_W-1] ? TOT_W'(-tot_r) : TOT_W'(tot_r);
    mag_sh  = abs_tot[TOT_W-1:32];
    mag_c   = (mag_sh > 48'(ANGLE_LIMIT)) ? ANGLE_LIMIT : mag_sh[MAG_W-1:0];
    ang     = negt_r ? $signed({1'b0, mag_r}) : -$signed({1'b0, mag_r});
    duty_w  = 46'(ang) * 46'sd6 + 46'(DUTY_OFFSET);
    if (duty_w < 0) begin
      duty_c = '0;
    end else if (|duty_w[45:24]) begin
      duty_c = '1;
    end else begin
      duty_c = duty_w[23:8];
    end
    if (ang > 42'sd32767) begin
      ang_c = 16'sh7fff;
    end else if (ang < -42'sd32768) begin
      ang_c = 16'sh8000;
    end else begin
      ang_c = ang[15:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      act_r       <= ACT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      act_r   <= act_nxt;
      if (do_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-axis history, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        raw1_r[i]  <= '0;
        raw2_r[i]  <= '0;
        filt1_r[i] <= '0;
        filt2_r[i] <= '0;
        perr_r[i]  <= '0;
        esum_r[i]  <= '0;
      end
    end else begin
      if (do_err) begin
        raw2_r[ax_r]  <= raw1_r[ax_r];
        raw1_r[ax_r]  <= x0_r;
        filt2_r[ax_r] <= filt1_r[ax_r];
        filt1_r[ax_r] <= y_cl;
        perr_r[ax_r]  <= e_c;
      end
      if (do_sum) begin
        esum_r[ax_r] <= s_c;
      end
    end
  end

  // Shared multiplier and the accumulators it feeds.
  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    if (q_pop) begin
      ax_r <= q_data.axis;
      x0_r <= q_data.raw_position;
    end
    if (latch_neg) begin
      xneg_r <= xsel[SUM_W-1];
    end
    if (clr) begin
      acc_r <= '0;
      tot_r <= '0;
    end else begin
      unique case (act_r)
        ACT_FILT_ADD: acc_r <= acc_r + $signed({1'b0, p_r[ACC_W-2:0]});
        ACT_FILT_SUB: acc_r <= acc_r - $signed({1'b0, p_r[ACC_W-2:0]});
        ACT_LOAD_M:   m_r   <= p_r[MUL_B_W-1:0];
        ACT_ADD_LO: begin
          if (xneg_r) begin
            tot_r <= tot_r - $signed({{(TOT_W-PROD_W){1'b0}}, p_r});
          end else begin
            tot_r <= tot_r + $signed({{(TOT_W-PROD_W){1'b0}}, p_r});
          end
        end
        ACT_ADD_HI: begin
          if (xneg_r) begin
            tot_r <= tot_r - $signed({2'b00, p_r, {MUL_A_W{1'b0}}});
          end else begin
            tot_r <= tot_r + $signed({2'b00, p_r, {MUL_A_W{1'b0}}});
          end
        end
        default: acc_r <= acc_r;
      endcase
    end
    if (do_err) begin
      y_r  <= y_cl;
      e_r  <= e_c;
      de_r <= de_c;
    end
    if (do_sum) begin
      s_r <= s_c;
    end
    if (do_mag) begin
      mag_r  <= mag_c;
      negt_r <= tot_r[TOT_W-1];
    end
    if (do_out) begin
      out_data_r.axis_out          <= ax_r;
      out_data_r.filtered_position <= y_r;
      out_data_r.angle_q8          <= ang_c;
      out_data_r.duty_us           <= duty_c;
    end
  end

endmodule

FILE: sv/two_axis_biquad_pid_servo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_axis_biquad_pid_servo: touch panel filter and PID servo controller
// Per-axis Butterworth biquad low-pass followed by a PID step and servo map.
// ----------------------------------------------------------------------------
// Each sample beat passes through these steps, from the time the engine picks
// it up from the queue until its result beat is loaded: the five filter
// products, the error and the saturated error sum, the three PID terms (each
// split into steps on the single shared 20x38 multiplier), the last
// accumulate, the magnitude, and the saturation with the output load. A
// two-entry queue in front takes new samples while the engine works, and the
// output register holds a finished beat while the engine runs the next one.
// Gains and setpoints sit on a 64-bit APB-style port at byte address 8*i and
// should be written only while no sample is in flight.
module two_axis_biquad_pid_servo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tabs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tabs_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [5:0]     paddr,
  input  logic [63:0]    pwdata,
  output logic [63:0]    prdata,
  output logic           pready
);
  import tabs_pkg::*;

  cfg_t cfg;
  logic q_valid;
  logic q_pop;
  in_t  q_data;

  // Register file.
  tabs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input queue.
  tabs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  // Filter and PID engine.
  tabs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: sv/tabs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabs_checker: port-level checks of the servo block
// Watches the result beats, the register port and the reset behavior at the top-level ports.
// ----------------------------------------------------------------------------
module tabs_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input tabs_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input tabs_pkg::out_t out_data,
  input logic           psel,
  input logic           penable,
  input logic           pwrite,
  input logic [5:0]     paddr,
  input logic [63:0]    pwdata,
  input logic [63:0]    prdata,
  input logic           pready
);
  import tabs_pkg::*;

  logic signed [31:0] exp_duty;
  logic               ang_free;

  // Duty expected from an angle that did not saturate.
  assign exp_duty = (32'(out_data.angle_q8) * 32'sd6 + 32'(DUTY_OFFSET)) >>> 8;
  assign ang_free = (out_data.angle_q8 != 16'sh7fff) && (out_data.angle_q8 != 16'sh8000);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Duty follows the angle when the angle is in range.
  a_duty_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ang_free |-> out_data.duty_us == exp_duty[15:0])
    else $error("duty does not match angle");

  // Register port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable |-> pready)
    else $error("register access stalled");

endmodule

bind two_axis_biquad_pid_servo tabs_checker u_tabs_checker (.*);
